>>> rtl/core/sfr_pkg.sv
// shared types and constants for the sensor frame receiver
// used by every module under rtl/core; depends on nothing
package sfr_pkg;

  localparam int FRAME_BYTES = 31;
  localparam int POS_W       = 5;
  localparam int SHIFT_DEPTH = FRAME_BYTES - 1;
  localparam int FIELD_WORDS = 10;
  localparam int NUM_WORDS   = FIELD_WORDS + 1;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W      = 4;

  localparam logic [POS_W-1:0] FRAME_LAST = POS_W'(FRAME_BYTES - 1);
  localparam logic [POS_W-1:0] SUM_FIRST  = POS_W'(1);
  localparam logic [POS_W-1:0] SUM_LAST   = POS_W'(28);

  localparam logic [7:0]  RESET_HEADER_FIRST  = 8'h42;
  localparam logic [7:0]  RESET_HEADER_SECOND = 8'h4D;
  localparam logic [15:0] RESET_CHECKSUM_SEED = 16'h006F;

  localparam logic [1:0] REG_HEADER_FIRST  = 2'd0;
  localparam logic [1:0] REG_HEADER_SECOND = 2'd1;
  localparam logic [1:0] REG_CHECKSUM_SEED = 2'd2;

  typedef enum logic [2:0] {
    ST_HUNT  = 3'b001,
    ST_FIRST = 3'b010,
    ST_FRAME = 3'b100
  } hunt_state_t;

  typedef enum logic {
    ITEM_START = 1'b0,
    ITEM_DATA  = 1'b1
  } item_kind_t;

  typedef struct packed {
    item_kind_t       kind;
    logic [POS_W-1:0] pos;
    logic [7:0]       data;
  } frame_item_t;

  typedef struct packed {
    logic [7:0]  header_first;
    logic [7:0]  header_second;
    logic [15:0] checksum_seed;
  } sfr_cfg_t;

endpackage

>>> rtl/core/sfr_front.sv
// front end: header hunt and byte classification into queue items
// depends on sfr_pkg
module sfr_front import sfr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  sfr_cfg_t    cfg,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        push,
  output frame_item_t push_item
);

  hunt_state_t      state, state_next;
  logic [POS_W-1:0] pos, pos_next;
  logic             accept;

  assign accept = in_valid && !in_stall;

  always_comb begin
    state_next          = state;
    pos_next            = pos;
    push                = 1'b0;
    push_item.kind      = ITEM_DATA;
    push_item.pos       = pos;
    push_item.data      = rx_byte;
    if (accept) begin
      unique case (state)
        ST_FRAME: begin
          push = 1'b1;
          if (pos == FRAME_LAST) begin
            state_next = ST_HUNT;
            pos_next   = '0;
          end else begin
            pos_next = pos + POS_W'(1);
          end
        end
        ST_HUNT, ST_FIRST: begin
          if (rx_byte == cfg.header_second) begin
            pos_next = '0;
            if (state == ST_FIRST) begin
              state_next     = ST_FRAME;
              push           = 1'b1;
              push_item.kind = ITEM_START;
            end else begin
              state_next = ST_HUNT;
            end
          end else if (rx_byte == cfg.header_first) begin
            state_next = ST_FIRST;
          end else begin
            state_next = ST_HUNT;
          end
        end
        default: state_next = ST_HUNT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_HUNT;
      pos   <= '0;
    end else begin
      state <= state_next;
      pos   <= pos_next;
    end
  end

endmodule

>>> rtl/core/sfr_queue.sv
// short item queue between front and back ends
// depends on sfr_pkg
module sfr_queue import sfr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  frame_item_t push_item,
  input  logic        pop,
  output logic        head_valid,
  output frame_item_t head_item,
  output logic        full
);

  frame_item_t       slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign head_valid = (count != '0);
  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("queue push while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("queue pop while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count out of range");

endmodule

>>> rtl/core/sfr_back.sv
// back end: frame buffer, running checksum, latched fields and result register
// depends on sfr_pkg
module sfr_back import sfr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  sfr_cfg_t    cfg,
  input  logic        head_valid,
  input  frame_item_t head_item,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        frame_good,
  output logic [15:0] payload_length,
  output logic [15:0] pm1_mass,
  output logic [15:0] pm2p5_mass,
  output logic [15:0] pm10_mass,
  output logic [15:0] count_0p3,
  output logic [15:0] count_0p5,
  output logic [15:0] count_1p0,
  output logic [15:0] count_2p5,
  output logic [15:0] count_5p0,
  output logic [15:0] count_10,
  output logic [15:0] frame_sum_field
);

  logic [7:0]  sreg  [SHIFT_DEPTH];
  logic [15:0] latch [NUM_WORDS];
  logic [15:0] running_sum;
  logic [15:0] frame_sum;
  logic        head_data, head_last, sum_good, in_sum;

  assign head_data = head_valid && (head_item.kind == ITEM_DATA);
  assign head_last = head_data && (head_item.pos == FRAME_LAST);
  assign in_sum    = (head_item.pos >= SUM_FIRST) && (head_item.pos <= SUM_LAST);
  assign pop       = head_valid && (!head_last || !out_valid || !out_stall);
  assign frame_sum = {sreg[0], head_item.data};
  assign sum_good  = (running_sum == frame_sum);

  always_ff @(posedge clk) begin
    if (pop && head_data) begin
      sreg[0] <= head_item.data;
      for (int i = 1; i < SHIFT_DEPTH; i++) begin
        sreg[i] <= sreg[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= RESET_CHECKSUM_SEED;
    end else if (pop && (head_item.kind == ITEM_START)) begin
      running_sum <= cfg.checksum_seed;
    end else if (pop && head_data && in_sum) begin
      running_sum <= running_sum + {8'h00, head_item.data};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_WORDS; k++) begin
        latch[k] <= '0;
      end
    end else if (pop && head_last && sum_good) begin
      for (int k = 0; k < FIELD_WORDS; k++) begin
        latch[k] <= {sreg[SHIFT_DEPTH-2-2*k], sreg[SHIFT_DEPTH-3-2*k]};
      end
      latch[FIELD_WORDS] <= frame_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      frame_good <= 1'b0;
    end else if (pop && head_last) begin
      out_valid  <= 1'b1;
      frame_good <= sum_good;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign payload_length  = latch[0];
  assign pm1_mass        = latch[1];
  assign pm2p5_mass      = latch[2];
  assign pm10_mass       = latch[3];
  assign count_0p3       = latch[4];
  assign count_0p5       = latch[5];
  assign count_1p0       = latch[6];
  assign count_2p5       = latch[7];
  assign count_5p0       = latch[8];
  assign count_10        = latch[9];
  assign frame_sum_field = latch[FIELD_WORDS];

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (pop && head_last) |-> !(out_valid && out_stall))
    else $error("result overwritten while stalled");
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(pop && head_last))
    else $error("result without a completed frame");
  a_latch_hold: assert property (@(posedge clk) disable iff (rst)
    !(pop && head_last && sum_good) |=> $stable(latch[FIELD_WORDS]) && $stable(latch[0]))
    else $error("latched store changed without a good frame");

endmodule

>>> rtl/core/sensor_frame_receiver_core.sv
// sensor frame receiver top level: config registers, front end, queue, back end
// depends on sfr_pkg, sfr_front, sfr_queue, sfr_back
// a frame's last accepted byte is written into a queue slot and then popped, which sets the registered out_valid
// throughput: one byte per cycle while in_stall is low; a stalled result holds while bytes keep queueing
// input stalls only when the 4-entry queue between front and back is full
// reset: registers return to 0x42, 0x4D, 0x006F; latched fields clear to zero; hunt restarts
module sensor_frame_receiver_core import sfr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        rx_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              frame_good,
  output logic [15:0]       payload_length,
  output logic [15:0]       pm1_mass,
  output logic [15:0]       pm2p5_mass,
  output logic [15:0]       pm10_mass,
  output logic [15:0]       count_0p3,
  output logic [15:0]       count_0p5,
  output logic [15:0]       count_1p0,
  output logic [15:0]       count_2p5,
  output logic [15:0]       count_5p0,
  output logic [15:0]       count_10,
  output logic [15:0]       frame_sum_field
);

  sfr_cfg_t    cfg;
  logic [1:0]  reg_index;
  logic        cfg_write;
  logic        push, pop, head_valid, full;
  frame_item_t push_item, head_item;

  assign pready    = 1'b1;
  assign reg_index = paddr[ADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_first  <= RESET_HEADER_FIRST;
      cfg.header_second <= RESET_HEADER_SECOND;
      cfg.checksum_seed <= RESET_CHECKSUM_SEED;
    end else if (cfg_write) begin
      unique case (reg_index)
        REG_HEADER_FIRST:  cfg.header_first  <= pwdata[7:0];
        REG_HEADER_SECOND: cfg.header_second <= pwdata[7:0];
        REG_CHECKSUM_SEED: cfg.checksum_seed <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_HEADER_FIRST:  prdata = {24'h0, cfg.header_first};
      REG_HEADER_SECOND: prdata = {24'h0, cfg.header_second};
      REG_CHECKSUM_SEED: prdata = {16'h0, cfg.checksum_seed};
      default:           prdata = '0;
    endcase
  end

  assign in_stall = full;

  sfr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .rx_byte   (rx_byte),
    .push      (push),
    .push_item (push_item)
  );

  sfr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item),
    .full       (full)
  );

  sfr_back u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .head_valid      (head_valid),
    .head_item       (head_item),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .frame_good      (frame_good),
    .payload_length  (payload_length),
    .pm1_mass        (pm1_mass),
    .pm2p5_mass      (pm2p5_mass),
    .pm10_mass       (pm10_mass),
    .count_0p3       (count_0p3),
    .count_0p5       (count_0p5),
    .count_1p0       (count_1p0),
    .count_2p5       (count_2p5),
    .count_5p0       (count_5p0),
    .count_10        (count_10),
    .frame_sum_field (frame_sum_field)
  );

endmodule

>>> dv/tb_sensor_frame_receiver_core.sv
// testbench for sensor_frame_receiver_core: directed and random byte streams with
// random idling, config writes over the register port, frame results checked per field
// depends on sfr_pkg and the sensor_frame_receiver_core rtl
`timescale 1ns / 100ps

module tb_sensor_frame_receiver_core;
  import sfr_pkg::*;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = 20;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASE_BYTES   = 220;
  localparam int PRINT_LIMIT   = 40;
  localparam logic [1:0] REG_SPARE = 2'd3;

  typedef logic [7:0] frame_bytes_t [FRAME_BYTES];

  typedef struct packed {
    logic                       good;
    logic [NUM_WORDS-1:0][15:0] words;
  } frame_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [7:0]        rx_byte = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              frame_good;
  logic [15:0]       payload_length, pm1_mass, pm2p5_mass, pm10_mass;
  logic [15:0]       count_0p3, count_0p5, count_1p0, count_2p5, count_5p0, count_10;
  logic [15:0]       frame_sum_field;

  sensor_frame_receiver_core uut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_stall, .rx_byte, .out_valid, .out_stall, .frame_good,
    .payload_length, .pm1_mass, .pm2p5_mass, .pm10_mass, .count_0p3, .count_0p5,
    .count_1p0, .count_2p5, .count_5p0, .count_10, .frame_sum_field
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  string word_names [NUM_WORDS] = '{"payload_length", "pm1_mass", "pm2p5_mass",
    "pm10_mass", "count_0p3", "count_0p5", "count_1p0", "count_2p5", "count_5p0",
    "count_10", "frame_sum_field"};

  // shadow of the block: config, deframer state, latched frame
  logic [7:0]  cfg_first  = RESET_HEADER_FIRST;
  logic [7:0]  cfg_second = RESET_HEADER_SECOND;
  logic [15:0] cfg_seed   = RESET_CHECKSUM_SEED;
  logic        hunt_seen_first = 1'b0;
  logic        hunt_in_frame   = 1'b0;
  int          frame_pos = 0;
  logic [15:0] frame_sum = RESET_CHECKSUM_SEED;
  frame_bytes_t rx_frame;
  frame_bytes_t latched_bytes = '{default: 8'h00};

  frame_result_t pending_frames[$];

  int fail_count   = 0;
  int cycle_count  = 0;
  int sent_bytes   = 0;
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  logic hold_on = 1'b0;
  event hold_trig;

  task automatic report_mismatch(input string msg);
    if (fail_count < PRINT_LIMIT) $display("mismatch @%0t: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic track_rx_byte(input logic [7:0] b);
    frame_result_t res;
    if (hunt_in_frame) begin
      rx_frame[frame_pos] = b;
      if (frame_pos >= SUM_FIRST && frame_pos <= SUM_LAST) frame_sum = frame_sum + b;
      if (frame_pos < FRAME_LAST) begin
        frame_pos++;
        return;
      end
      res.good = (frame_sum == {rx_frame[FRAME_BYTES-2], rx_frame[FRAME_BYTES-1]});
      if (res.good) latched_bytes = rx_frame;
      for (int i = 0; i < FIELD_WORDS; i++)
        res.words[i] = {latched_bytes[2*i+1], latched_bytes[2*i+2]};
      res.words[FIELD_WORDS] = {latched_bytes[FRAME_BYTES-2], latched_bytes[FRAME_BYTES-1]};
      pending_frames.push_back(res);
      hunt_in_frame = 1'b0;
      hunt_seen_first = 1'b0;
      frame_pos = 0;
    end else if (b == cfg_second) begin
      // second header wins over first, so equal headers never open a frame
      if (hunt_seen_first) begin
        hunt_in_frame = 1'b1;
        frame_sum = cfg_seed;
      end
      hunt_seen_first = 1'b0;
      frame_pos = 0;
    end else begin
      hunt_seen_first = (b == cfg_first);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    frame_result_t want;
    logic [NUM_WORDS-1:0][15:0] got;
    if (!rst && out_valid && !out_stall) begin
      got = {frame_sum_field, count_10, count_5p0, count_2p5, count_1p0, count_0p5,
             count_0p3, pm10_mass, pm2p5_mass, pm1_mass, payload_length};
      if (pending_frames.size() == 0) begin
        report_mismatch("result transaction with no frame pending");
      end else begin
        want = pending_frames.pop_front();
        if (frame_good !== want.good)
          report_mismatch($sformatf("frame_good got %b want %b", frame_good, want.good));
        for (int i = 0; i < NUM_WORDS; i++)
          if (got[i] !== want.words[i])
            report_mismatch($sformatf("%s got %h want %h", word_names[i], got[i],
                                      want.words[i]));
      end
    end
  end

  // receiver stall: random per cycle, or held for a long stretch on request
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= hold_on || (rx_stall_pct != 0 && $urandom_range(99, 0) < rx_stall_pct);
    end
  end

  always @(hold_trig) begin
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_HEADER_FIRST:  cfg_first  = val[7:0];
      REG_HEADER_SECOND: cfg_second = val[7:0];
      REG_CHECKSUM_SEED: cfg_seed   = val[15:0];
      default: ;
    endcase
  endtask

  task automatic reg_read(input logic [1:0] idx, output logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_W'({idx, 2'b00});
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    val = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_regs();
    logic [31:0] v;
    reg_read(REG_HEADER_FIRST, v);
    if (v[7:0] !== cfg_first)
      report_mismatch($sformatf("header_first reads %h want %h", v[7:0], cfg_first));
    reg_read(REG_HEADER_SECOND, v);
    if (v[7:0] !== cfg_second)
      report_mismatch($sformatf("header_second reads %h want %h", v[7:0], cfg_second));
    reg_read(REG_CHECKSUM_SEED, v);
    if (v[15:0] !== cfg_seed)
      report_mismatch($sformatf("checksum_seed reads %h want %h", v[15:0], cfg_seed));
  endtask

  // upper bits carry junk to exercise masking
  task automatic set_config(input logic [7:0] hf, input logic [7:0] hs, input logic [15:0] sd);
    reg_write(REG_HEADER_FIRST, {24'($urandom), hf});
    reg_write(REG_HEADER_SECOND, {24'($urandom), hs});
    reg_write(REG_CHECKSUM_SEED, {16'($urandom), sd});
  endtask

  task automatic send_byte(input logic [7:0] b);
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (in_stall);
    track_rx_byte(b);
    sent_bytes++;
    if (tx_idle_pct != 0 && $urandom_range(99, 0) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99, 0) < tx_idle_pct);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_byte(input int hdr_pct);
    int r;
    r = $urandom_range(99, 0);
    if (r < hdr_pct) return ($urandom_range(1, 0) != 0) ? cfg_first : cfg_second;
    if (r < hdr_pct + 6) return ($urandom_range(1, 0) != 0) ? 8'hFF : 8'h00;
    return 8'($urandom_range(255, 0));
  endfunction

  // fill < 0 gives random content
  task automatic build_frame(input bit corrupt, input int hdr_pct, input int fill,
                             output frame_bytes_t body);
    logic [15:0] sum;
    sum = cfg_seed;
    for (int i = 0; i < FRAME_BYTES - 2; i++) begin
      body[i] = (fill < 0) ? pick_byte(hdr_pct) : 8'(fill);
      if (i >= SUM_FIRST && i <= SUM_LAST) sum = sum + body[i];
    end
    if (corrupt) sum = sum ^ 16'($urandom_range(65535, 1));
    body[FRAME_BYTES-2] = sum[15:8];
    body[FRAME_BYTES-1] = sum[7:0];
  endtask

  task automatic send_body(input frame_bytes_t body, input int lo, input int hi);
    for (int i = lo; i <= hi; i++) send_byte(body[i]);
  endtask

  task automatic send_frame(input bit corrupt, input int hdr_pct, input int fill);
    frame_bytes_t body;
    build_frame(corrupt, hdr_pct, fill, body);
    send_byte(cfg_first);
    send_byte(cfg_second);
    send_body(body, 0, FRAME_BYTES - 1);
  endtask

  task automatic test_reset_frames();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    check_regs();
    send_frame(1'b1, 0, -1);  // bad before any good: zeros
    send_frame(1'b0, 0, -1);
    send_frame(1'b1, 0, -1);  // bad after good: last good stays
    wait_idle();
  endtask

  task automatic test_hunt_order();
    send_byte(cfg_second);
    send_byte(cfg_first);
    send_byte(8'h00);
    send_byte(cfg_second);
    send_byte(cfg_first);
    send_frame(1'b0, 0, -1);   // first, first, second opens a frame
    send_frame(1'b0, 60, -1);  // header bytes inside the frame are data
    send_frame(1'b0, 0, -1);
    wait_idle();
  endtask

  task automatic test_register_extremes();
    frame_bytes_t body;
    set_config(8'h00, 8'hFF, 16'hFFFF);
    check_regs();
    send_frame(1'b0, 0, 8'hFF);
    send_frame(1'b0, 30, -1);
    wait_idle();
    set_config(8'hFF, 8'h00, 16'h0000);
    check_regs();
    send_frame(1'b0, 0, 8'h00);
    send_frame(1'b1, 30, -1);
    wait_idle();
    reg_write(REG_SPARE, $urandom);
    check_regs();
    // equal headers never open a frame
    set_config(8'h5A, 8'h5A, 16'h1234);
    send_byte(8'h5A);
    send_byte(8'h5A);
    send_byte(8'h5A);
    build_frame(1'b0, 20, -1, body);
    send_body(body, 0, FRAME_BYTES - 1);
    wait_idle();
    set_config(RESET_HEADER_FIRST, RESET_HEADER_SECOND, RESET_CHECKSUM_SEED);
    send_frame(1'b0, 0, -1);
    wait_idle();
  endtask

  task automatic test_midframe_changes();
    frame_bytes_t body;
    logic [7:0] hs;
    // seed written inside a frame applies to the next one
    build_frame(1'b0, 0, -1, body);
    send_byte(cfg_first);
    send_byte(cfg_second);
    send_body(body, 0, 14);
    wait_idle();
    reg_write(REG_CHECKSUM_SEED, $urandom);
    send_body(body, 15, FRAME_BYTES - 1);
    send_frame(1'b0, 0, -1);
    wait_idle();
    // header written while hunting takes effect on the next byte
    send_byte(cfg_first);
    wait_idle();
    do hs = 8'($urandom_range(255, 0)); while (hs == cfg_first);
    reg_write(REG_HEADER_SECOND, {24'h0, hs});
    send_byte(hs);
    build_frame(1'b0, 10, -1, body);
    send_body(body, 0, FRAME_BYTES - 1);
    wait_idle();
  endtask

  task automatic test_backpressure();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    -> hold_trig;
    repeat (4) send_frame(1'b0, 10, -1);
    wait_idle();
  endtask

  task automatic run_random_phase(input int tx_pct, input int rx_pct, input int n);
    int base;
    int r;
    logic [7:0] hf, hs;
    hf = 8'($urandom_range(255, 0));
    do hs = 8'($urandom_range(255, 0)); while (hs == hf);
    set_config(hf, hs, ($urandom_range(3, 0) == 0) ? 16'hFFFF : 16'($urandom));
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    base = sent_bytes;
    while (sent_bytes - base < n) begin
      r = $urandom_range(99, 0);
      if (r < 70) begin
        send_frame($urandom_range(99, 0) < 15, $urandom_range(12, 0), -1);
      end else if (r < 78) begin
        send_byte(cfg_first);
        send_byte(pick_byte(30));
      end else if (r < 84) begin
        send_byte(cfg_first);
        send_byte(cfg_second);
        repeat ($urandom_range(29, 1)) send_byte(pick_byte(5));
      end else begin
        repeat ($urandom_range(8, 1)) send_byte(pick_byte(20));
      end
    end
    wait_idle();
  endtask

  task automatic test_random();
    run_random_phase(0, 0, PHASE_BYTES);
    run_random_phase(69, 0, PHASE_BYTES);
    run_random_phase(0, 69, PHASE_BYTES);
    run_random_phase(27, 27, PHASE_BYTES);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_frames();
    test_hunt_order();
    test_register_extremes();
    test_midframe_changes();
    test_backpressure();
    test_random();
    wait_idle();
    if (pending_frames.size() != 0)
      report_mismatch($sformatf("%0d frame results never arrived", pending_frames.size()));
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
